>>> design/q2y_pkg.sv
// Shared types and constants for the quaternion-to-yaw pipeline.
// Standalone package; imported by quaternion_to_yaw.
package q2y_pkg;

    localparam int QUAT_W     = 16;
    localparam int PROD_W     = 32;
    localparam int XY_W       = 36;   // CORDIC x/y, covers gain growth of 2^33 vectors
    localparam int ANG_W      = 34;   // Q30 angle accumulator, covers +-(pi + sum of atans)
    localparam int RND_W      = ANG_W + 1;
    localparam int YAW_W      = 16;
    localparam int YAW_FULL_W = 18;
    localparam int FRAC_SHIFT = 17;   // Q30 to Q13
    localparam int ATAN_LEN   = 24;
    localparam int YAW_LIMIT  = 25736;

    localparam logic signed [ANG_W-1:0] PI_Q30     = 34'sd3373259426;
    localparam logic signed [RND_W-1:0] ROUND_HALF = 35'sd65536;

    typedef struct packed {
        logic signed [PROD_W-1:0] wz;
        logic signed [PROD_W-1:0] xy;
        logic signed [PROD_W-1:0] ww;
        logic signed [PROD_W-1:0] xx;
        logic signed [PROD_W-1:0] yy;
        logic signed [PROD_W-1:0] zz;
        logic                     zero;
    } prod_t;

    typedef struct packed {
        logic signed [XY_W-1:0] sy;
        logic signed [XY_W-1:0] cx;
        logic                   zero;
    } sum_t;

    typedef struct packed {
        logic signed [XY_W-1:0]  xs;
        logic signed [XY_W-1:0]  ys;
        logic signed [ANG_W-1:0] ang;
        logic                    special;  // zero quaternion or both arguments zero
        logic                    zero;
    } cord_t;

    // atan(2^-idx) in signed Q30 radians
    function automatic logic signed [ANG_W-1:0] atan_q30(input int idx);
        logic signed [ANG_W-1:0] r;
        unique case (idx)
            0:       r = 34'sd843314857;
            1:       r = 34'sd497837829;
            2:       r = 34'sd263043837;
            3:       r = 34'sd133525159;
            4:       r = 34'sd67021687;
            5:       r = 34'sd33543516;
            6:       r = 34'sd16775851;
            7:       r = 34'sd8388437;
            8:       r = 34'sd4194283;
            9:       r = 34'sd2097149;
            10:      r = 34'sd1048576;
            11:      r = 34'sd524288;
            12:      r = 34'sd262144;
            13:      r = 34'sd131072;
            14:      r = 34'sd65536;
            15:      r = 34'sd32768;
            16:      r = 34'sd16384;
            17:      r = 34'sd8192;
            18:      r = 34'sd4096;
            19:      r = 34'sd2048;
            20:      r = 34'sd1024;
            21:      r = 34'sd512;
            22:      r = 34'sd256;
            default: r = 34'sd128;
        endcase
        return r;
    endfunction

endpackage

>>> design/quaternion_to_yaw.sv
// Top level of the quaternion-to-yaw converter: product, sum, quadrant,
// CORDIC and rounding stages. Depends on q2y_pkg.
//
// Usage
//   Slave channel s_*: one beat carries one quaternion (w, x, y, z), each a
//   signed Q14 value. Master channel m_*: one beat carries the yaw about Z,
//   atan2(2(wz+xy), w^2+x^2-y^2-z^2), as signed Q13 radians in -pi..pi, and
//   a zero_norm flag in tuser that marks an all-zero quaternion (yaw 0).
//   A quaternion whose two atan2 arguments both vanish also gives yaw 0.
// Throughput and pipeline
//   One beat per cycle sustained while m_tready stays high. The pipeline
//   has NUM_ITER + 4 register stages: multiply, sum, quadrant fold, one
//   stage per CORDIC micro-rotation, then round and saturate. The CORDIC
//   stage chain sets the latency; each stage holds one adder pair and the
//   angle add.
// Reset
//   aresetn (synchronous, active low) clears every stage valid bit; the
//   data registers keep whatever they held.
// Stall
//   Each stage loads when it is empty or its successor loads, so a stalled
//   m_tready holds the output beat while upstream bubbles close up; s_tready
//   drops only once every stage holds a beat. Nothing is lost or repeated.
module quaternion_to_yaw #(
    parameter int CORDIC_ITERATIONS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // quat_real[15:0], quat_i[31:16], quat_j[47:32], quat_k[63:48]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // yaw_angle[15:0]
    output logic        m_tuser    // zero_norm[0]
);
    import q2y_pkg::*;

    localparam int NUM_ITER = (CORDIC_ITERATIONS > ATAN_LEN) ? ATAN_LEN : CORDIC_ITERATIONS;
    // stage 0 products, 1 sums, 2 quadrant fold, 3..NUM_ITER+2 CORDIC, last output
    localparam int NSTAGE   = NUM_ITER + 4;
    localparam int OUT_IDX  = NSTAGE - 1;

    logic [NSTAGE-1:0] vld_reg;
    logic [NSTAGE:0]   rdy;

    // Ready chain: a stage loads when empty or when its successor loads.
    assign rdy[NSTAGE] = m_tready;
    for (genvar i = 0; i < NSTAGE; i++) begin : g_vld
        assign rdy[i] = !vld_reg[i] || rdy[i+1];
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[i] <= 1'b0;
            end else if (rdy[i]) begin
                vld_reg[i] <= (i == 0) ? s_tvalid : vld_reg[(i == 0) ? 0 : i - 1];
            end
        end
    end

    assign s_tready = rdy[0];

    // Stage 0: six 16x16 products and the all-zero flag.
    logic signed [QUAT_W-1:0] q_w, q_x, q_y, q_z;
    prod_t prod_next, prod_reg;

    assign q_w = $signed(s_tdata[15:0]);
    assign q_x = $signed(s_tdata[31:16]);
    assign q_y = $signed(s_tdata[47:32]);
    assign q_z = $signed(s_tdata[63:48]);

    always_comb begin
        prod_next.wz   = q_w * q_z;
        prod_next.xy   = q_x * q_y;
        prod_next.ww   = q_w * q_w;
        prod_next.xx   = q_x * q_x;
        prod_next.yy   = q_y * q_y;
        prod_next.zz   = q_z * q_z;
        prod_next.zero = (s_tdata == 64'd0);
    end

    always_ff @(posedge aclk) begin
        if (rdy[0]) begin
            prod_reg <= prod_next;
        end
    end

    // Stage 1: form the two atan2 arguments exactly.
    sum_t sum_next, sum_reg;

    always_comb begin
        sum_next.sy   = (XY_W'(prod_reg.wz) + XY_W'(prod_reg.xy)) <<< 1;
        sum_next.cx   = XY_W'(prod_reg.ww) + XY_W'(prod_reg.xx)
                      - XY_W'(prod_reg.yy) - XY_W'(prod_reg.zz);
        sum_next.zero = prod_reg.zero;
    end

    always_ff @(posedge aclk) begin
        if (rdy[1]) begin
            sum_reg <= sum_next;
        end
    end

    // Stage 2: fold the left half plane by +-pi, flag degenerate arguments.
    cord_t cord_reg  [NUM_ITER+1];
    cord_t cord_next [NUM_ITER+1];

    always_comb begin
        cord_next[0].special = sum_reg.zero || ((sum_reg.sy == '0) && (sum_reg.cx == '0));
        cord_next[0].zero    = sum_reg.zero;
        if (sum_reg.cx < 0) begin
            cord_next[0].ang = (sum_reg.sy >= 0) ? PI_Q30 : -PI_Q30;
            cord_next[0].xs  = -sum_reg.cx;
            cord_next[0].ys  = -sum_reg.sy;
        end else begin
            cord_next[0].ang = '0;
            cord_next[0].xs  = sum_reg.cx;
            cord_next[0].ys  = sum_reg.sy;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[2]) begin
            cord_reg[0] <= cord_next[0];
        end
    end

    // CORDIC vectoring: one micro-rotation per stage, driving y toward zero.
    for (genvar k = 0; k < NUM_ITER; k++) begin : g_cordic
        always_comb begin
            cord_next[k+1] = cord_reg[k];
            if (cord_reg[k].ys >= 0) begin
                cord_next[k+1].xs  = cord_reg[k].xs + (cord_reg[k].ys >>> k);
                cord_next[k+1].ys  = cord_reg[k].ys - (cord_reg[k].xs >>> k);
                cord_next[k+1].ang = cord_reg[k].ang + atan_q30(k);
            end else begin
                cord_next[k+1].xs  = cord_reg[k].xs - (cord_reg[k].ys >>> k);
                cord_next[k+1].ys  = cord_reg[k].ys + (cord_reg[k].xs >>> k);
                cord_next[k+1].ang = cord_reg[k].ang - atan_q30(k);
            end
        end

        always_ff @(posedge aclk) begin
            if (rdy[k+3]) begin
                cord_reg[k+1] <= cord_next[k+1];
            end
        end
    end

    // Output stage: round Q30 to Q13 half up, saturate, force zero on special.
    logic signed [RND_W-1:0]      rnd;
    logic signed [YAW_FULL_W-1:0] yaw_full;
    logic signed [YAW_W-1:0]      yaw_next, yaw_reg;
    logic                         zero_reg;

    assign rnd      = RND_W'(cord_reg[NUM_ITER].ang) + ROUND_HALF;
    assign yaw_full = YAW_FULL_W'(rnd >>> FRAC_SHIFT);

    always_comb begin
        priority if (cord_reg[NUM_ITER].special) begin
            yaw_next = '0;
        end else if (yaw_full > YAW_FULL_W'(YAW_LIMIT)) begin
            yaw_next = YAW_W'(YAW_LIMIT);
        end else if (yaw_full < -YAW_FULL_W'(YAW_LIMIT)) begin
            yaw_next = -YAW_W'(YAW_LIMIT);
        end else begin
            yaw_next = YAW_W'(yaw_full);
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[OUT_IDX]) begin
            yaw_reg  <= yaw_next;
            zero_reg <= cord_reg[NUM_ITER].zero;
        end
    end

    assign m_tvalid = vld_reg[OUT_IDX];
    assign m_tdata  = yaw_reg;
    assign m_tuser  = zero_reg;

    // A zero quaternion must leave with a zero angle.
    a_zero_yaw: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata == 16'd0)
        else $error("zero_norm beat with nonzero yaw");

    // The angle stays within -pi..pi in Q13.
    a_yaw_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ($signed(m_tdata) <= 16'sd25736) && ($signed(m_tdata) >= -16'sd25736))
        else $error("yaw out of range");

    // With the output stage empty the whole pipeline can take a beat.
    a_ready_free: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output stage");

    // A beat taken at the output frees the input in the same cycle, so this antecedent never holds.
    a_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !s_tready |=> s_tready)
        else $error("input still stalled after output drained");

endmodule
